// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sound speed profile block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, codes and reset profile of the sound speed profile interpolator.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int DEPTH_W = 20;
   localparam int SPEED_W = 19;
   localparam int INDEX_W = 3;
   localparam int SEG_W   = 3;
   localparam int RC_W    = 2;
   localparam int COUNT_W = 4;
   localparam int CSR_W   = 19;
   localparam int CSR_IDX_W = 1;

   // Slots that a request can address through its 3-bit index
   localparam int LOADABLE = 8;

   // Divider: one quotient bit per step, quotient never wider than a speed
   localparam int QBITS = SPEED_W;
   localparam int CNT_W = 5;
   localparam int PROD_W = SPEED_W + DEPTH_W;

   // Request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SPEED = 1'b1;

   // Range codes
   localparam logic [RC_W-1:0] RC_INTERP  = 2'd0;
   localparam logic [RC_W-1:0] RC_SHALLOW = 2'd1;
   localparam logic [RC_W-1:0] RC_DEEP    = 2'd2;
   localparam logic [RC_W-1:0] RC_DEFAULT = 2'd3;

   // Register reset values
   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET   = 4'd7;
   localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RESET = 19'd384000;

   typedef struct packed {
      logic               opcode;
      logic [INDEX_W-1:0] point_index;
      logic [DEPTH_W-1:0] depth;
      logic [SPEED_W-1:0] speed;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] sound_speed;
      logic [SEG_W-1:0]   segment;
      logic [RC_W-1:0]    range_case;
   } rsp_type;

   // Breakpoint write broadcast to the cell row
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [DEPTH_W-1:0] depth;
      logic [SPEED_W-1:0] speed;
   } load_type;

   // Query token that walks the cell row
   typedef struct packed {
      logic               valid;
      logic [DEPTH_W-1:0] depth;
      logic [DEPTH_W-1:0] prev_d;
      logic [SPEED_W-1:0] prev_s;
      logic               shallow;
      logic               deep;
      logic [SPEED_W-1:0] res_spd;
      logic               found;
      logic [SEG_W-1:0]   seg;
      logic [DEPTH_W-1:0] d0;
      logic [DEPTH_W-1:0] d1;
      logic [SPEED_W-1:0] s0;
      logic [SPEED_W-1:0] s1;
   } tok_type;

   typedef enum logic [2:0] {
      DV_IDLE,
      DV_MULT,
      DV_DIVIDE,
      DV_APPLY,
      DV_FINISH
   } div_state_type;

   // Built-in profile, slots past the seventh are zero
   function automatic logic [DEPTH_W-1:0] init_depth(input int k);
      unique case (k)
         0: return 20'd0;
         1: return 20'd800;
         2: return 20'd3200;
         3: return 20'd8000;
         4: return 20'd16000;
         5: return 20'd32000;
         6: return 20'd64000;
         default: return '0;
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] init_speed(input int k);
      unique case (k)
         0: return 19'd391680;
         1: return 19'd386560;
         2: return 19'd381440;
         3: return 19'd378880;
         4: return 19'd380160;
         5: return 19'd384000;
         6: return 19'd389120;
         default: return '0;
      endcase
   endfunction

endpackage

// File: rtl/core/ssp_cell.sv
// ----------------------------------------------------------------------------
// ssp_cell
// One breakpoint of the profile. Holds its depth and speed, checks the
// passing query token against its segment and forwards the token.
// ----------------------------------------------------------------------------
module ssp_cell #(
   parameter int CELL_INDEX = 0,
   parameter int NW         = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [NW-1:0]    n_eff,
   input  ssp_pkg::load_type load,
   input  ssp_pkg::tok_type tok_in,
   output ssp_pkg::tok_type tok_out
);
   import ssp_pkg::*;

   localparam logic [NW-1:0] IDX    = NW'(CELL_INDEX);
   localparam logic [NW-1:0] LAST_N = NW'(CELL_INDEX + 1);
   localparam int            SEG_ID = (CELL_INDEX == 0) ? 0 : CELL_INDEX - 1;
   localparam logic          CAN_LOAD = (CELL_INDEX < LOADABLE);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   tok_type            tok_ff, tok_in_nxt;
   logic               active, last, hit;

   assign active = (IDX < n_eff);
   assign last   = (LAST_N == n_eff);
   assign hit    = CAN_LOAD && load.en && (load.index == INDEX_W'(CELL_INDEX));

   // Breakpoint write
   always_comb begin
      depth_in = depth_ff;
      speed_in = speed_ff;
      if (hit) begin
         depth_in = load.depth;
         speed_in = load.speed;
      end
   end

   // Token update: shallow clamp at the head, segment test, deep clamp at the end
   always_comb begin
      tok_in_nxt = tok_in;
      if (CELL_INDEX == 0 && active && tok_in.depth <= depth_ff) begin
         tok_in_nxt.shallow = 1'b1;
         tok_in_nxt.res_spd = speed_ff;
      end
      if (CELL_INDEX >= 1 && active && !tok_in.found &&
          tok_in.depth >= tok_in.prev_d && tok_in.depth <= depth_ff) begin
         tok_in_nxt.found = 1'b1;
         tok_in_nxt.seg   = SEG_W'(SEG_ID);
         tok_in_nxt.d0    = tok_in.prev_d;
         tok_in_nxt.s0    = tok_in.prev_s;
         tok_in_nxt.d1    = depth_ff;
         tok_in_nxt.s1    = speed_ff;
      end
      if (last && !tok_in_nxt.shallow && tok_in.depth >= depth_ff) begin
         tok_in_nxt.deep    = 1'b1;
         tok_in_nxt.res_spd = speed_ff;
      end
      tok_in_nxt.prev_d = depth_ff;
      tok_in_nxt.prev_s = speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= init_depth(CELL_INDEX);
         speed_ff <= init_speed(CELL_INDEX);
         tok_ff   <= '0;
      end else begin
         depth_ff <= depth_in;
         speed_ff <= speed_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: rtl/core/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div
// Resolves the token leaving the cell row and, for an interpolated request,
// runs one multiply and a restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  ssp_pkg::tok_type        tok_in,
   input  logic                    empty,
   input  logic [ssp_pkg::SPEED_W-1:0] default_speed,
   output logic                    rsp_valid,
   output ssp_pkg::rsp_type        rsp_item
);
   import ssp_pkg::*;

   div_state_type      state_ff, state_in;
   logic [SPEED_W-1:0] res_ff, res_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [RC_W-1:0]    rc_ff, rc_in;
   logic [SPEED_W-1:0] s0_ff, s0_in;
   logic               neg_ff, neg_in;
   logic [SPEED_W-1:0] ds_ff, ds_in;
   logic [DEPTH_W-1:0] off_ff, off_in;
   logic [DEPTH_W-1:0] span_ff, span_in;
   logic [DEPTH_W-1:0] rem_ff, rem_in;
   logic [QBITS-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [PROD_W-1:0]  prod;
   logic [DEPTH_W+1:0] trial;

   assign prod  = PROD_W'(ds_ff) * PROD_W'(off_ff);
   assign trial = {1'b0, rem_ff, lo_ff[QBITS-1]} - {2'b00, span_ff};

   // Next state and datapath
   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      seg_in   = seg_ff;
      rc_in    = rc_ff;
      s0_in    = s0_ff;
      neg_in   = neg_ff;
      ds_in    = ds_ff;
      off_in   = off_ff;
      span_in  = span_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (tok_in.valid) begin
               state_in = DV_FINISH;
               seg_in   = '0;
               priority if (empty) begin
                  res_in = default_speed;
                  rc_in  = RC_DEFAULT;
               end else if (tok_in.shallow) begin
                  res_in = tok_in.res_spd;
                  rc_in  = RC_SHALLOW;
               end else if (tok_in.deep) begin
                  res_in = tok_in.res_spd;
                  rc_in  = RC_DEEP;
               end else if (tok_in.found) begin
                  rc_in  = RC_INTERP;
                  seg_in = tok_in.seg;
                  res_in = tok_in.s0;
                  s0_in  = tok_in.s0;
                  neg_in = (tok_in.s1 < tok_in.s0);
                  ds_in  = (tok_in.s1 < tok_in.s0) ? tok_in.s0 - tok_in.s1
                                                   : tok_in.s1 - tok_in.s0;
                  off_in  = tok_in.depth - tok_in.d0;
                  span_in = tok_in.d1 - tok_in.d0;
                  // zero-width segment keeps its first speed
                  if (tok_in.d1 != tok_in.d0) begin
                     state_in = DV_MULT;
                  end
               end else begin
                  res_in = default_speed;
                  rc_in  = RC_DEFAULT;
               end
            end
         end
         DV_MULT: begin
            // quotient fits QBITS, so the upper product bits stay below span
            rem_in   = prod[PROD_W-1:QBITS];
            lo_in    = prod[QBITS-1:0];
            cnt_in   = '0;
            state_in = DV_DIVIDE;
         end
         DV_DIVIDE: begin
            if (!trial[DEPTH_W+1]) begin
               rem_in = trial[DEPTH_W-1:0];
            end else begin
               rem_in = {rem_ff[DEPTH_W-2:0], lo_ff[QBITS-1]};
            end
            lo_in  = {lo_ff[QBITS-2:0], !trial[DEPTH_W+1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QBITS - 1)) begin
               state_in = DV_APPLY;
            end
         end
         DV_APPLY: begin
            res_in   = neg_ff ? s0_ff - lo_ff : s0_ff + lo_ff;
            state_in = DV_FINISH;
         end
         DV_FINISH: begin
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      seg_ff  <= seg_in;
      rc_ff   <= rc_in;
      s0_ff   <= s0_in;
      neg_ff  <= neg_in;
      ds_ff   <= ds_in;
      off_ff  <= off_in;
      span_ff <= span_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp_valid            = (state_ff == DV_FINISH);
   assign rsp_item.sound_speed = res_ff;
   assign rsp_item.segment     = seg_ff;
   assign rsp_item.range_case  = rc_ff;

   // Remainder stays below the divisor throughout the divide
   `ASSERT_CLK_RST(a_rem_below_span, clock, reset, (state_ff == DV_DIVIDE) |-> (rem_ff < span_ff), "divider remainder not below span")
   // A token only arrives when the unit is free
   `ASSERT_CLK_RST(a_tok_when_idle, clock, reset, tok_in.valid |-> (state_ff == DV_IDLE), "token arrived while divider busy")

endmodule

// File: rtl/core/sound_speed_profile_interpolator.sv
// ----------------------------------------------------------------------------
// sound_speed_profile_interpolator
// Piecewise linear sound speed lookup over a loadable breakpoint profile.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         start & !busy
//  result    rsp_valid, rsp_item            out        one-cycle strobe
//  csr       csr_we, csr_index, csr_wdata   in         write on csr_we
//
//  A load request gives no result.
//  A query walks the row of PROFILE_POINTS cells, one cell per cycle, and
//  is resolved in the divider; an interpolated one also passes through one
//  multiply plus a 19-step restoring divide before its result strobes.
//  busy stays high until the strobe, so a new request can be taken the
//  cycle after it.
//  Synchronous reset restores the built-in profile and register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sound_speed_profile_interpolator #(
   parameter int PROFILE_POINTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ssp_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   output ssp_pkg::rsp_type                  rsp_item,
   input  logic                              csr_we,
   input  logic [ssp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssp_pkg::CSR_W-1:0]         csr_wdata
);
   import ssp_pkg::*;

   localparam int NW = $clog2(PROFILE_POINTS + 1);
   localparam logic [7:0] POINTS8 = 8'(PROFILE_POINTS);

   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic [SPEED_W-1:0] default_speed_ff, default_speed_in;
   logic               busy_ff, busy_in;
   logic               accept, query_accept;
   logic [7:0]         count8, n8;
   logic [NW-1:0]      n_eff;
   load_type           load;
   tok_type            tok_head;
   tok_type            chain [PROFILE_POINTS+1];

   assign accept       = start && !busy_ff;
   assign query_accept = accept && (req_item.opcode == OP_QUERY);

   // Configuration registers
   always_comb begin
      point_count_in   = point_count_ff;
      default_speed_in = default_speed_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POINT_COUNT:   point_count_in   = csr_wdata[COUNT_W-1:0];
            CSR_DEFAULT_SPEED: default_speed_in = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Busy from query accept until its result strobe
   always_comb begin
      busy_in = busy_ff;
      if (rsp_valid) begin
         busy_in = 1'b0;
      end else if (query_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= POINT_COUNT_RESET;
         default_speed_ff <= DEFAULT_SPEED_RESET;
         busy_ff          <= 1'b0;
      end else begin
         point_count_ff   <= point_count_in;
         default_speed_ff <= default_speed_in;
         busy_ff          <= busy_in;
      end
   end

   assign busy = busy_ff;

   // Breakpoints in use, counts past the row act as the full row
   assign count8 = 8'(point_count_ff);
   assign n8     = (count8 > POINTS8) ? POINTS8 : count8;
   assign n_eff  = n8[NW-1:0];

   // Load broadcast
   assign load.en    = accept && (req_item.opcode == OP_LOAD);
   assign load.index = req_item.point_index;
   assign load.depth = req_item.depth;
   assign load.speed = req_item.speed;

   // Fresh token entering the row
   always_comb begin
      tok_head       = '0;
      tok_head.valid = query_accept;
      tok_head.depth = req_item.depth;
   end

   assign chain[0] = tok_head;

   // Cell row
   for (genvar k = 0; k < PROFILE_POINTS; k++) begin : g_cell
      ssp_cell #(
         .CELL_INDEX(k),
         .NW        (NW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .n_eff  (n_eff),
         .load   (load),
         .tok_in (chain[k]),
         .tok_out(chain[k+1])
      );
   end

   // Resolve and divide
   ssp_div u_div (
      .clock        (clock),
      .reset        (reset),
      .tok_in       (chain[PROFILE_POINTS]),
      .empty        (n_eff == '0),
      .default_speed(default_speed_ff),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

   // A result only comes for a query in flight, and frees the block
   `ASSERT_CLK_RST(a_rsp_while_busy, clock, reset, rsp_valid |-> busy_ff, "result strobe without a query in flight")
   `ASSERT_CLK_RST(a_free_after_rsp, clock, reset, rsp_valid |=> !busy_ff, "block still busy after result")
   // Only interpolated results name a segment
   `ASSERT_CLK_RST(a_seg_zero, clock, reset, (rsp_valid && (rsp_item.range_case != RC_INTERP)) |-> (rsp_item.segment == '0), "clamped or default result with nonzero segment")

endmodule
